### rtl/core/msc_pkg.sv
// shared constants and types for the mpeg-4 start code frame scanner
// no dependencies; used by the top level, the frame clock and the checker
package msc_pkg;

  localparam int CounterWidthDef = 32;
  localparam int IdxW            = 32;
  localparam int TsW             = 38;

  // timestamp in ms: index * MsPerSec / FrameRate, kept as whole part plus fraction
  localparam int MsPerSec  = 1000;
  localparam int FrameRate = 30;
  localparam int TsStep    = MsPerSec / FrameRate;
  localparam int TsFrac    = MsPerSec % FrameRate;
  localparam int FracW     = $clog2(FrameRate);

  localparam logic [2:0] WINDOW_FULL     = 3'd4;
  localparam logic [1:0] SKIP_AFTER_CODE = 2'd3;

  localparam logic [7:0] START_PREFIX    = 8'h01;
  localparam logic [7:0] SHORT_MASK      = 8'hfc;
  localparam logic [7:0] SHORT_PREFIX    = 8'h80;
  localparam logic [7:0] SHORT_TAIL_MASK = 8'h03;
  localparam logic [7:0] SHORT_TAIL      = 8'h02;
  localparam logic [7:0] VOP_CODE        = 8'hb6;

  typedef struct packed {
    logic clear;  // stream restart, applied before this transaction
    logic step;   // a frame was found in this transaction
  } fc_ctrl_t;

endpackage

### rtl/core/mpeg4_start_code_frame_scanner.sv
// MPEG-4 start code frame scanner, top level
// Usage: bytes of a video elementary stream enter on the in_ channel, one per
// transaction, with in_stream_start marking the first byte of a new stream
// (window, counters and short mode clear before that byte). The block looks
// for start codes 00 00 01 xx and short-header picture codes; after a code it
// ignores three byte positions. On the byte after a frame code it emits one
// out_ transaction: frame type, short mode, frame index, offset of the code
// and index*1000/30 ms. Bytes that start no frame give no output.
// Each byte waits in the input register; its result is registered in out_.
// Throughput: one byte per cycle while out_stall holds back no result; the
// input register, one pass of compare logic and the output register form the
// pipeline, and the timestamp is advanced by an add per frame, not a multiply.
// Stall: while out_stall holds back a waiting result, the byte in the input
// register waits and in_stall goes high; a byte arriving while the result is
// taken moves on in the same cycle.
// Reset: synchronous, active low; control state clears, data registers do not;
// no result is pending and a byte is accepted in the first cycle after reset.
// depends on msc_pkg and msc_frame_clock
module mpeg4_start_code_frame_scanner #(
  parameter int COUNTER_WIDTH = msc_pkg::CounterWidthDef
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_stream_start,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                out_frame_type,
  output logic                      out_short_mode,
  output logic [msc_pkg::IdxW-1:0]  out_frame_index,
  output logic [msc_pkg::IdxW-1:0]  out_frame_offset,
  output logic [msc_pkg::TsW-1:0]   out_timestamp_ms
);
  import msc_pkg::*;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;

  // scan state
  logic [31:0]              win_r, win_nxt;
  logic [2:0]               fill_r, fill_nxt;
  logic [1:0]               skip_r, skip_nxt;
  logic                     short_r, short_nxt;
  logic [COUNTER_WIDTH-1:0] pos_r, pos_nxt;

  // result register
  logic            out_valid_r;
  logic [1:0]      type_r, type_nxt;
  logic            smode_r;
  logic [IdxW-1:0] index_r, index_nxt;
  logic [IdxW-1:0] offset_r, offset_nxt;
  logic [TsW-1:0]  ts_r;

  logic                     fire;
  logic [31:0]              win_c;
  logic [2:0]               fill_c;
  logic [1:0]               skip_c;
  logic                     short_c;
  logic [COUNTER_WIDTH-1:0] pos_c;
  logic [7:0]               b0, b1, b2, b3;
  logic                     full, code_ok, normal_hit, short_hit, match, frame;
  logic [COUNTER_WIDTH-1:0] fc_count;
  logic [TsW-1:0]           fc_stamp;
  fc_ctrl_t                 fc_ctrl;

  assign fire     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;

  always_comb begin
    win_c   = s1_start_r ? '0 : win_r;
    fill_c  = s1_start_r ? '0 : fill_r;
    skip_c  = s1_start_r ? '0 : skip_r;
    short_c = s1_start_r ? 1'b0 : short_r;
    pos_c   = s1_start_r ? '0 : pos_r;
    b0 = win_c[31:24];
    b1 = win_c[23:16];
    b2 = win_c[15:8];
    b3 = win_c[7:0];

    full       = fill_c == WINDOW_FULL;
    code_ok    = full && (skip_c == '0) && (b0 == '0) && (b1 == '0);
    normal_hit = code_ok && (b2 == START_PREFIX);
    short_hit  = code_ok && !normal_hit && ((b2 & SHORT_MASK) == SHORT_PREFIX)
                 && ((b3 & SHORT_TAIL_MASK) == SHORT_TAIL);
    match      = normal_hit || short_hit;
    short_nxt  = short_c || short_hit;
    frame      = match && (short_nxt || (b3 == VOP_CODE));

    if (match) begin
      skip_nxt = SKIP_AFTER_CODE;
    end else if (full && (skip_c != '0)) begin
      skip_nxt = skip_c - 1'b1;
    end else begin
      skip_nxt = skip_c;
    end
    win_nxt  = {win_c[23:0], s1_byte_r};
    fill_nxt = full ? fill_c : fill_c + 1'b1;
    pos_nxt  = pos_c + 1'b1;

    type_nxt   = short_nxt ? {1'b0, s1_byte_r[1]} : s1_byte_r[7:6];
    index_nxt  = IdxW'(fc_count);
    // code's first byte sits four positions back
    offset_nxt = IdxW'(pos_c - COUNTER_WIDTH'(4));

    fc_ctrl.clear = fire && s1_start_r;
    fc_ctrl.step  = fire && frame;
  end

  msc_frame_clock #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_frame_clock (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (fc_ctrl),
    .count (fc_count),
    .stamp (fc_stamp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r  <= in_data_byte;
      s1_start_r <= in_stream_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      fill_r  <= '0;
      skip_r  <= '0;
      short_r <= 1'b0;
      pos_r   <= '0;
    end else if (fire) begin
      win_r   <= win_nxt;
      fill_r  <= fill_nxt;
      skip_r  <= skip_nxt;
      short_r <= short_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= frame;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && frame) begin
      type_r   <= type_nxt;
      smode_r  <= short_nxt;
      index_r  <= index_nxt;
      offset_r <= offset_nxt;
      ts_r     <= fc_stamp;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_type   = type_r;
  assign out_short_mode   = smode_r;
  assign out_frame_index  = index_r;
  assign out_frame_offset = offset_r;
  assign out_timestamp_ms = ts_r;

endmodule

### rtl/core/msc_frame_clock.sv
// frame counter and millisecond timestamp for the start code scanner
// the timestamp is carried incrementally (whole ms plus a fraction), no multiplier
// depends on msc_pkg
module msc_frame_clock #(
  parameter int COUNTER_WIDTH = msc_pkg::CounterWidthDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  msc_pkg::fc_ctrl_t             ctrl,
  output logic [COUNTER_WIDTH-1:0]      count,
  output logic [msc_pkg::TsW-1:0]       stamp
);
  import msc_pkg::*;

  logic [COUNTER_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [TsW-1:0]           ts_r, ts_nxt;
  logic [FracW-1:0]         frac_r, frac_nxt;
  logic [FracW:0]           frac_sum;
  logic                     carry;

  always_comb begin
    count    = ctrl.clear ? '0 : cnt_r;
    stamp    = ctrl.clear ? '0 : ts_r;
    frac_sum = {1'b0, (ctrl.clear ? '0 : frac_r)} + (FracW+1)'(TsFrac);
    carry    = frac_sum >= (FracW+1)'(FrameRate);
    cnt_nxt  = count;
    ts_nxt   = stamp;
    frac_nxt = ctrl.clear ? '0 : frac_r;
    if (ctrl.step) begin
      cnt_nxt = count + 1'b1;
      if (&count) begin
        // counter wraps to zero, so does its timestamp
        ts_nxt   = '0;
        frac_nxt = '0;
      end else begin
        ts_nxt   = stamp + TsW'(TsStep) + TsW'(carry);
        frac_nxt = carry ? FracW'(frac_sum - (FracW+1)'(FrameRate)) : FracW'(frac_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ts_r   <= '0;
      frac_r <= '0;
    end else if (ctrl.clear || ctrl.step) begin
      cnt_r  <= cnt_nxt;
      ts_r   <= ts_nxt;
      frac_r <= frac_nxt;
    end
  end

endmodule

### rtl/core/msc_checker.sv
// port-level checks for the start code frame scanner, bound to the top level
// depends on msc_pkg and mpeg4_start_code_frame_scanner
module msc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [1:0]                out_frame_type,
  input logic                      out_short_mode,
  input logic [msc_pkg::IdxW-1:0]  out_frame_index,
  input logic [msc_pkg::IdxW-1:0]  out_frame_offset,
  input logic [msc_pkg::TsW-1:0]   out_timestamp_ms
);
  import msc_pkg::*;

  // a held result stays valid and keeps its index, offset and timestamp
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_index)
      && $stable(out_frame_offset) && $stable(out_timestamp_ms))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // short-header pictures only report intra or inter
  a_short_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_short_mode |-> out_frame_type[1] == 1'b0)
    else $error("short mode frame type out of range");

  // timestamp is zero exactly for the first frame
  a_ts_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_frame_index == '0) == (out_timestamp_ms == '0)))
    else $error("timestamp does not follow frame index");

endmodule

bind mpeg4_start_code_frame_scanner msc_checker u_msc_checker (.*);

### sim/mpeg4_start_code_frame_scanner_tb.sv
// testbench for mpeg4_start_code_frame_scanner: directed table, then random byte streams
// depends on msc_pkg and the scanner rtl; frame reports are checked against a local predictor
module mpeg4_start_code_frame_scanner_tb;
  import msc_pkg::*;

  localparam int NumDirRows    = 35;
  localparam int RandomBytes   = 1200;
  localparam int HoldCycles    = 80;
  localparam int WatchdogLimit = 2000;

  typedef struct packed {
    logic [1:0]      ftype;
    logic            short_mode;
    logic [IdxW-1:0] index;
    logic [IdxW-1:0] offset;
    logic [TsW-1:0]  ts;
  } frame_rec_t;

  // typed rows carry the frame report they must produce
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       typed;
    frame_rec_t rec;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [NumDirRows] = '{
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{START_PREFIX, 1'b0, 1'b0, '0},
    '{VOP_CODE, 1'b0, 1'b0, '0},
    // first frame right after reset: predicted, index 0, offset 0
    '{8'h40, 1'b0, 1'b1, '{2'd1, 1'b0, 32'd0, 32'd0, 38'd0}},
    '{8'hff, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{START_PREFIX, 1'b0, 1'b0, '0},
    '{VOP_CODE, 1'b0, 1'b0, '0},
    // sprite frame, second index
    '{8'hc0, 1'b0, 1'b1, '{2'd3, 1'b0, 32'd1, 32'd6, 38'd33}},
    // non-frame code right after a frame: no report, but it arms the skip
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{START_PREFIX, 1'b0, 1'b0, '0},
    '{8'hb3, 1'b0, 1'b0, '0},
    // VOP code once the skip has run out: reported, as the predictor expects
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{START_PREFIX, 1'b0, 1'b0, '0},
    '{VOP_CODE, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, '0},
    // short-header picture code switches to short mode
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h82, 1'b0, 1'b0, '0},
    '{8'h06, 1'b0, 1'b0, '0},
    '{8'h02, 1'b0, 1'b1, '{2'd1, 1'b1, 32'd3, 32'd20, 38'd100}},
    // short prefix with wrong tail bits
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h83, 1'b0, 1'b0, '0},
    '{8'h03, 1'b0, 1'b0, '0},
    '{8'hff, 1'b0, 1'b0, '0},
    // restart in the middle of a code: window is not full again yet
    '{8'h00, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{START_PREFIX, 1'b0, 1'b0, '0},
    '{VOP_CODE, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0}
  };

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [7:0]      in_data_byte = 8'h00;
  logic            in_stream_start = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [1:0]      out_frame_type;
  logic            out_short_mode;
  logic [IdxW-1:0] out_frame_index;
  logic [IdxW-1:0] out_frame_offset;
  logic [TsW-1:0]  out_timestamp_ms;

  mpeg4_start_code_frame_scanner dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_stream_start (in_stream_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_type  (out_frame_type),
    .out_short_mode  (out_short_mode),
    .out_frame_index (out_frame_index),
    .out_frame_offset(out_frame_offset),
    .out_timestamp_ms(out_timestamp_ms)
  );

  // predictor state
  logic [31:0] scan_window = '0;
  logic [2:0]  scan_fill = '0;
  logic [1:0]  scan_skip = '0;
  logic        scan_short = 1'b0;
  logic [31:0] scan_pos = '0;
  logic [31:0] frame_count = '0;

  frame_rec_t pending_frames[$];
  frame_rec_t want;

  int  err_count = 0;
  int  bytes_sent = 0;
  int  restarts = 0;
  int  frames_checked = 0;
  int  short_frames = 0;
  int  quiet_cycles = 0;
  bit  send_gaps_on = 1'b1;
  bit  recv_gaps_on = 1'b1;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  bit  pause_done = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void predict_frame(input logic [7:0] cur, input logic restart,
                                        output bit hit, output frame_rec_t rec);
    logic [7:0]  b0, b1, b2, b3;
    logic        start_code, short_code;
    logic [63:0] wide;
    hit = 1'b0;
    rec = '0;
    if (restart) begin
      scan_window = '0;
      scan_fill   = '0;
      scan_skip   = '0;
      scan_short  = 1'b0;
      scan_pos    = '0;
      frame_count = '0;
    end
    if (scan_fill >= WINDOW_FULL) begin
      {b0, b1, b2, b3} = scan_window;
      if (scan_skip != 2'd0) begin
        scan_skip = scan_skip - 2'd1;
      end else if (b0 == 8'h00 && b1 == 8'h00) begin
        start_code = (b2 == START_PREFIX);
        short_code = !start_code && ((b2 & SHORT_MASK) == SHORT_PREFIX) &&
                     ((b3 & SHORT_TAIL_MASK) == SHORT_TAIL);
        if (start_code || short_code) begin
          if (short_code) scan_short = 1'b1;
          scan_skip = SKIP_AFTER_CODE;
          if (scan_short || b3 == VOP_CODE) begin
            rec.ftype      = scan_short ? {1'b0, cur[1]} : cur[7:6];
            rec.short_mode = scan_short;
            rec.index      = frame_count;
            rec.offset     = scan_pos - 32'd4;
            wide = ({32'd0, frame_count} * 64'(MsPerSec)) / 64'(FrameRate);
            rec.ts         = wide[TsW-1:0];
            frame_count    = frame_count + 32'd1;
            hit = 1'b1;
          end
        end
      end
    end
    scan_window = {scan_window[23:0], cur};
    if (scan_fill < WINDOW_FULL) scan_fill = scan_fill + 3'd1;
    scan_pos = scan_pos + 32'd1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
    err_count++;
    $display("mismatch %0d: %s expected 0x%0h got 0x%0h", err_count, what, exp_v, got_v);
  endtask

  // holds the transaction until taken; valid stays high for back-to-back bytes
  task automatic send_byte(input logic [7:0] d, input logic restart);
    while (send_gaps_on && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= d;
    in_stream_start <= restart;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    bytes_sent++;
    if (restart) restarts++;
  endtask

  task automatic feed_byte(input logic [7:0] d, input logic restart);
    bit         hit;
    frame_rec_t rec;
    send_byte(d, restart);
    predict_frame(d, restart, hit, rec);
    if (hit) pending_frames.push_back(rec);
  endtask

  // mostly well-formed codes with random content, some broken prefixes, noise and restarts
  task automatic feed_burst();
    int         kind;
    int         n;
    logic [7:0] tail;
    kind = $urandom_range(99);
    if (kind < 5) begin
      feed_byte(8'($urandom_range(255)), 1'b1);
    end else if (kind < 45) begin
      feed_byte(8'h00, 1'b0);
      feed_byte(8'h00, 1'b0);
      feed_byte(START_PREFIX, 1'b0);
      feed_byte($urandom_range(1) ? VOP_CODE : 8'($urandom_range(255)), 1'b0);
      n = $urandom_range(3, 1);
      repeat (n) feed_byte(8'($urandom_range(255)), 1'b0);
    end else if (kind < 65) begin
      tail = 8'($urandom_range(255));
      if ($urandom_range(3) != 0) tail = (tail & ~SHORT_TAIL_MASK) | SHORT_TAIL;
      feed_byte(8'h00, 1'b0);
      feed_byte(8'h00, 1'b0);
      feed_byte(SHORT_PREFIX | 8'($urandom_range(3)), 1'b0);
      feed_byte(tail, 1'b0);
      n = $urandom_range(2, 1);
      repeat (n) feed_byte(8'($urandom_range(255)), 1'b0);
    end else if (kind < 80) begin
      feed_byte(8'h00, 1'b0);
      feed_byte(8'h00, 1'b0);
      feed_byte($urandom_range(1) ? 8'h00 : 8'($urandom_range(255)), 1'b0);
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) feed_byte(($urandom_range(2) == 0) ? 8'h00 : 8'($urandom_range(255)), 1'b0);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= recv_gaps_on && ($urandom_range(99) < 35);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("frame report with none pending, offset", 64'd0,
                        64'(out_frame_offset));
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        if (out_short_mode) short_frames++;
        if (out_frame_type !== want.ftype)
          report_mismatch("frame_type", 64'(want.ftype), 64'(out_frame_type));
        if (out_short_mode !== want.short_mode)
          report_mismatch("short_mode", 64'(want.short_mode), 64'(out_short_mode));
        if (out_frame_index !== want.index)
          report_mismatch("frame_index", 64'(want.index), 64'(out_frame_index));
        if (out_frame_offset !== want.offset)
          report_mismatch("frame_offset", 64'(want.offset), 64'(out_frame_offset));
        if (out_timestamp_ms !== want.ts)
          report_mismatch("timestamp_ms", 64'(want.ts), 64'(out_timestamp_ms));
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: no transaction for %0d cycles", quiet_cycles);
      $display("mpeg4_start_code_frame_scanner test failed");
      $finish;
    end
  end

  initial begin
    bit         hit;
    frame_rec_t rec;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NumDirRows; i++) begin
      send_byte(DIR_ROWS[i].data, DIR_ROWS[i].restart);
      predict_frame(DIR_ROWS[i].data, DIR_ROWS[i].restart, hit, rec);
      if (DIR_ROWS[i].typed) pending_frames.push_back(DIR_ROWS[i].rec);
      else if (hit) pending_frames.push_back(rec);
    end

    while (bytes_sent < NumDirRows + RandomBytes) begin
      if (!hold_done && bytes_sent >= 400) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!pause_done && bytes_sent >= 700) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_frames.size() != 0) @(posedge clk);
        pause_done = 1'b1;
      end
      // back-to-back stretch on both sides
      send_gaps_on = !(bytes_sent >= 850 && bytes_sent < 1050);
      recv_gaps_on = send_gaps_on;
      feed_burst();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d bytes with %0d stream restarts, checked %0d frame reports",
             bytes_sent, restarts, frames_checked);
    $display("%0d reports in short-header mode, long receiver hold-off and drain pause done",
             short_frames);
    if (err_count == 0) begin
      $display("mpeg4_start_code_frame_scanner test passed");
    end else begin
      $display("mpeg4_start_code_frame_scanner test failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/msc_pkg.sv
rtl/core/msc_frame_clock.sv
rtl/core/mpeg4_start_code_frame_scanner.sv
rtl/core/msc_checker.sv
sim/mpeg4_start_code_frame_scanner_tb.sv
